// ===== hw/rtl/lft_pkg.sv =====
`timescale 1ns / 1ps

package lft_pkg;

  localparam int NumFrames = 16;
  localparam int OwnerBits = 8;
  localparam int FrameW    = 4;
  localparam int OwnerW    = 8;
  localparam int CntW      = $clog2(NumFrames + 1);

  localparam logic [1:0] CmdTouch = 2'd0;
  localparam logic [1:0] CmdEvict = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StDone  = 2'd2;

  typedef struct packed {
    logic                 en;
    logic                 touch;
    logic                 evict;
    logic [FrameW-1:0]    frame;
    logic [OwnerBits-1:0] owner;
  } lft_ctl_t;

endpackage

// ===== hw/rtl/lft_cell.sv =====
`timescale 1ns / 1ps

module lft_cell (
  input  logic                         clk_i,
  input  lft_pkg::lft_ctl_t            ctl_i,
  input  logic                         valid_i,
  input  logic                         prev_valid_i,
  input  logic                         next_valid_i,
  input  logic                         shift_i,
  input  logic [lft_pkg::FrameW-1:0]   nb_frame_i,
  input  logic [lft_pkg::OwnerBits-1:0] nb_owner_i,
  output logic                         shift_o,
  output logic                         hit_o,
  output logic [lft_pkg::FrameW-1:0]   frame_o,
  output logic [lft_pkg::OwnerBits-1:0] owner_o
);

  logic [lft_pkg::FrameW-1:0]    frame_q, frame_d;
  logic [lft_pkg::OwnerBits-1:0] owner_q, owner_d;
  logic                          moving;
  logic                          take_nb;
  logic                          take_new;

  assign hit_o   = valid_i & (frame_q == ctl_i.frame);
  assign moving  = shift_i | hit_o;
  assign shift_o = moving;

  // pull from the younger neighbor when the gap from a hit or evict passes by
  assign take_nb  = ctl_i.en & (ctl_i.evict | (ctl_i.touch & moving & next_valid_i));
  // tail takes the re-touched frame; first empty cell takes an appended one
  assign take_new = ctl_i.en & ctl_i.touch &
                    ((valid_i & ~next_valid_i & moving) |
                     (~valid_i & prev_valid_i & ~shift_i));

  always_comb begin
    frame_d = frame_q;
    owner_d = owner_q;
    if (take_new) begin
      frame_d = ctl_i.frame;
      owner_d = ctl_i.owner;
    end else if (take_nb) begin
      frame_d = nb_frame_i;
      owner_d = nb_owner_i;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    owner_q <= owner_d;
  end

  assign frame_o = frame_q;
  assign owner_o = owner_q;

endmodule

// ===== hw/rtl/lru_frame_tracker_core.sv =====
`timescale 1ns / 1ps

// LRU replacement list of up to NumFrames distinct frame numbers, each with the
// owner id last recorded for it. Commands: touch (move a frame to the newest end
// or append it, storing its owner; a touch of an absent frame on a full list is
// ignored), evict (remove the oldest frame and return it with its owner, or
// report an empty list), clear. Every command returns one result with the
// occupancy after it. One transaction is accepted per clock cycle and its result
// appears in the output register on the next cycle: the list is a chain of
// cells that all compare the frame against their entry and shift toward the
// old end in the same cycle, so the compare-and-shift across the
// chain sets the rate. The input stalls only while a finished result is held
// by a stalled output.
module lru_frame_tracker_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [lft_pkg::FrameW-1:0]  frame_i,
  input  logic [lft_pkg::OwnerW-1:0]  owner_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lft_pkg::FrameW-1:0]  evicted_frame_o,
  output logic [lft_pkg::OwnerW-1:0]  evicted_owner_o,
  output logic [1:0]                  status_o,
  output logic [lft_pkg::CntW-1:0]    occupancy_o
);

  localparam int N = lft_pkg::NumFrames;

  lft_pkg::lft_ctl_t              ctl;
  logic                           accept;
  logic [lft_pkg::CntW-1:0]       count_q, count_d;
  logic [N-1:0]                   valid_vec;
  logic [N-1:0]                   hit_vec;
  logic [N-1:0]                   shift_vec;
  logic [lft_pkg::FrameW-1:0]     cell_frame [N];
  logic [lft_pkg::OwnerBits-1:0]  cell_owner [N];
  logic                           any_hit;
  logic                           out_valid_q;
  logic [lft_pkg::FrameW-1:0]     ev_frame_q, ev_frame_d;
  logic [lft_pkg::OwnerW-1:0]     ev_owner_q, ev_owner_d;
  logic [1:0]                     status_q, status_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign ctl.en    = accept;
  assign ctl.touch = (cmd_i == lft_pkg::CmdTouch);
  assign ctl.evict = (cmd_i == lft_pkg::CmdEvict) & (count_q != '0);
  assign ctl.frame = frame_i;
  assign ctl.owner = owner_i[lft_pkg::OwnerBits-1:0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic prev_v, next_v, sh_in;
    logic [lft_pkg::FrameW-1:0]    nb_f;
    logic [lft_pkg::OwnerBits-1:0] nb_o;

    assign valid_vec[i] = (lft_pkg::CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
      assign sh_in  = 1'b0;
    end else begin : g_mid
      assign prev_v = valid_vec[i-1];
      assign sh_in  = shift_vec[i-1];
    end

    if (i == N - 1) begin : g_last
      assign next_v = 1'b0;
      assign nb_f   = cell_frame[i];
      assign nb_o   = cell_owner[i];
    end else begin : g_inner
      assign next_v = valid_vec[i+1];
      assign nb_f   = cell_frame[i+1];
      assign nb_o   = cell_owner[i+1];
    end

    lft_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .valid_i      (valid_vec[i]),
      .prev_valid_i (prev_v),
      .next_valid_i (next_v),
      .shift_i      (sh_in),
      .nb_frame_i   (nb_f),
      .nb_owner_i   (nb_o),
      .shift_o      (shift_vec[i]),
      .hit_o        (hit_vec[i]),
      .frame_o      (cell_frame[i]),
      .owner_o      (cell_owner[i])
    );
  end

  assign any_hit = shift_vec[N-1];

  always_comb begin
    count_d    = count_q;
    ev_frame_d = '0;
    ev_owner_d = '0;
    status_d   = lft_pkg::StOk;
    unique case (cmd_i)
      lft_pkg::CmdTouch: begin
        status_d = lft_pkg::StDone;
        if (!any_hit && count_q != lft_pkg::CntW'(N)) begin
          count_d = count_q + 1'b1;
        end
      end
      lft_pkg::CmdEvict: begin
        if (count_q == '0) begin
          status_d = lft_pkg::StEmpty;
        end else begin
          ev_frame_d = cell_frame[0];
          ev_owner_d = lft_pkg::OwnerW'(cell_owner[0]);
          count_d    = count_q - 1'b1;
        end
      end
      lft_pkg::CmdClear: begin
        status_d = lft_pkg::StDone;
        count_d  = '0;
      end
      default: begin
        status_d = lft_pkg::StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_frame_q <= ev_frame_d;
      ev_owner_q <= ev_owner_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign evicted_frame_o = ev_frame_q;
  assign evicted_owner_o = ev_owner_q;
  assign status_o        = status_q;
  assign occupancy_o     = count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lft_pkg::CntW'(N))
    else $error("occupancy above capacity");

  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("frame held in more than one cell");

  a_empty_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i == lft_pkg::CmdEvict && count_q == '0 |=>
      status_q == lft_pkg::StEmpty && count_q == '0)
    else $error("evict on empty list mishandled");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i == lft_pkg::CmdClear |=> count_q == '0 && out_valid_q)
    else $error("clear did not empty the list");
`endif

endmodule

// ===== sim/lru_frame_tracker_core_tb.sv =====
`timescale 1ns / 1ps

module lru_frame_tracker_core_tb;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 60;
  localparam int RandomItems = 700;

  typedef struct packed {
    logic [lft_pkg::FrameW-1:0] frame;
    logic [lft_pkg::OwnerW-1:0] owner;
    logic [1:0]                 status;
    logic [lft_pkg::CntW-1:0]   occupancy;
  } lru_result_t;

  class lru_order_model;
    logic [lft_pkg::FrameW-1:0]    frames[lft_pkg::NumFrames];
    logic [lft_pkg::OwnerBits-1:0] owners[lft_pkg::NumFrames];
    int unsigned                   count;
    lru_result_t                   pending_results[$];
    int                            errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Predict the result of one accepted command and update the recency order.
    function void note_command(logic [1:0] c, logic [lft_pkg::FrameW-1:0] f,
                               logic [lft_pkg::OwnerW-1:0] o);
      lru_result_t r;
      int hit;
      r = '0;
      case (c)
        lft_pkg::CmdTouch: begin
          hit = count;
          for (int i = 0; i < count; i++) begin
            if (frames[i] == f && hit == count) hit = i;
          end
          if (hit < count) begin
            for (int i = hit; i + 1 < count; i++) begin
              frames[i] = frames[i+1];
              owners[i] = owners[i+1];
            end
            frames[count-1] = f;
            owners[count-1] = o[lft_pkg::OwnerBits-1:0];
          end else if (count < lft_pkg::NumFrames) begin
            frames[count] = f;
            owners[count] = o[lft_pkg::OwnerBits-1:0];
            count++;
          end
          r.status = lft_pkg::StDone;
        end
        lft_pkg::CmdEvict: begin
          if (count == 0) begin
            r.status = lft_pkg::StEmpty;
          end else begin
            r.frame = frames[0];
            r.owner = lft_pkg::OwnerW'(owners[0]);
            for (int i = 0; i + 1 < count; i++) begin
              frames[i] = frames[i+1];
              owners[i] = owners[i+1];
            end
            count--;
            r.status = lft_pkg::StOk;
          end
        end
        lft_pkg::CmdClear: begin
          count    = 0;
          r.status = lft_pkg::StDone;
        end
        default: r.status = lft_pkg::StOk;
      endcase
      r.occupancy = lft_pkg::CntW'(count);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [lft_pkg::FrameW-1:0] f, logic [lft_pkg::OwnerW-1:0] o,
                               logic [1:0] s, logic [lft_pkg::CntW-1:0] occ);
      lru_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: frame %0d owner %0d status %0d occupancy %0d",
               f, o, s, occ);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (f !== e.frame) begin
        $error("evicted_frame: expected %0d, actual %0d", e.frame, f);
        errors++;
      end
      if (o !== e.owner) begin
        $error("evicted_owner: expected %0d, actual %0d", e.owner, o);
        errors++;
      end
      if (s !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, s);
        errors++;
      end
      if (occ !== e.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", e.occupancy, occ);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 cmd_i = lft_pkg::CmdTouch;
  logic [lft_pkg::FrameW-1:0] frame_i = '0;
  logic [lft_pkg::OwnerW-1:0] owner_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [lft_pkg::FrameW-1:0] evicted_frame_o;
  logic [lft_pkg::OwnerW-1:0] evicted_owner_o;
  logic [1:0]                 status_o;
  logic [lft_pkg::CntW-1:0]   occupancy_o;

  lru_order_model lru_model;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req  = 1'b0;

  lru_frame_tracker_core u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .cmd_i,
    .frame_i,
    .owner_i,
    .out_valid_o,
    .out_stall_i,
    .evicted_frame_o,
    .evicted_owner_o,
    .status_o,
    .occupancy_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Offer one transaction and hold it until it is accepted.
  task automatic send_cmd(logic [1:0] c, logic [lft_pkg::FrameW-1:0] f,
                          logic [lft_pkg::OwnerW-1:0] o);
    bit stalled;
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    frame_i    <= f;
    owner_i    <= o;
    // Sample stall mid-cycle: it holds its value up to the next rising edge.
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    lru_model.note_command(c, f, o);
  endtask

  // Result side: check accepted transactions, drive stall.
  initial begin
    int hold_left;
    bit take;
    logic [lft_pkg::FrameW-1:0] f_s;
    logic [lft_pkg::OwnerW-1:0] o_s;
    logic [1:0]                 s_s;
    logic [lft_pkg::CntW-1:0]   occ_s;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      take  = rst_ni && out_valid_o && !out_stall_i;
      f_s   = evicted_frame_o;
      o_s   = evicted_owner_o;
      s_s   = status_o;
      occ_s = occupancy_o;
      @(posedge clk_i);
      if (take) lru_model.check_result(f_s, o_s, s_s, occ_s);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("FAIL lru_frame_tracker_core");
        $finish;
      end
    end
  end

  initial begin
    int touch_pct;
    int pick;
    logic [1:0] c;
    logic [lft_pkg::FrameW-1:0] f;
    lru_model = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 29;
    recv_idle = 69;

    // Directed: empty evict, unused command, move, newest-frame touch, full list.
    send_cmd(lft_pkg::CmdEvict, 4'd0, 8'd0);
    send_cmd(CmdUnused, 4'd15, 8'hff);
    send_cmd(lft_pkg::CmdTouch, 4'd0, 8'h00);
    send_cmd(lft_pkg::CmdTouch, 4'd15, 8'hff);
    send_cmd(lft_pkg::CmdTouch, 4'd0, 8'haa);
    send_cmd(lft_pkg::CmdTouch, 4'd0, 8'h55);
    for (int i = 1; i < 15; i++) begin
      send_cmd(lft_pkg::CmdTouch, lft_pkg::FrameW'(i), lft_pkg::OwnerW'(i * 17));
    end
    send_cmd(lft_pkg::CmdTouch, 4'd7, 8'h80);
    send_cmd(CmdUnused, 4'd3, 8'h01);
    send_cmd(lft_pkg::CmdEvict, 4'd9, 8'h3c);
    send_cmd(lft_pkg::CmdEvict, 4'd0, 8'h00);
    send_cmd(lft_pkg::CmdClear, 4'd5, 8'h7f);
    send_cmd(lft_pkg::CmdEvict, 4'd0, 8'h00);

    touch_pct = 60;
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 233) begin
        send_idle = 69;
        recv_idle = 29;
      end
      if (n == 466) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (n == 20 || n == 560) hold_req = 1'b1;
      // Vary the mix so the list drains to empty and fills up in turn.
      if (n % 50 == 0) begin
        pick = $urandom_range(2);
        touch_pct = (pick == 0) ? 25 : (pick == 1) ? 60 : 90;
      end
      pick = $urandom_range(99);
      if (pick < 3) c = lft_pkg::CmdClear;
      else if (pick < 7) c = CmdUnused;
      else if ($urandom_range(99) < touch_pct) c = lft_pkg::CmdTouch;
      else c = lft_pkg::CmdEvict;
      f = ($urandom_range(3) == 0) ? lft_pkg::FrameW'($urandom_range(3)) :
                                     lft_pkg::FrameW'($urandom_range(15));
      send_cmd(c, f, lft_pkg::OwnerW'($urandom_range(255)));
    end
    in_valid_i <= 1'b0;

    while (lru_model.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (lru_model.errors == 0 && lru_model.pending() == 0) begin
      $display("PASS lru_frame_tracker_core");
    end else begin
      $display("FAIL lru_frame_tracker_core");
    end
    $finish;
  end

endmodule
